@@ rtl/ffha_pkg.sv @@
// shared types and constants for the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int HeapBytes   = 4096;
  localparam int AlignBytes  = 8;
  localparam int HeaderBytes = 16;
  localparam int MinPayload  = 32;

  localparam int SizeW  = 13;
  localparam int NeedW  = 17;
  localparam int Depth  = HeapBytes / AlignBytes;
  localparam int IdxW   = $clog2(Depth);
  localparam int AlignW = $clog2(AlignBytes);

  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic             used;
    logic [SizeW-1:0] size;
  } tag_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    tag_t wdata;
    idx_t raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_NOFIT  = 3'd2,
    ST_NULL   = 3'd3,
    ST_NOTBLK = 3'd4,
    ST_TWICE  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_WR,
    S_F_EV,
    S_F_NX,
    S_F_WB,
    S_F_PR,
    S_F_PE,
    S_F_PM,
    S_DONE
  } state_e;

endpackage

@@ rtl/first_fit_heap_allocator_top.sv @@
// first-fit heap allocator top level
// alloc reads and checks each block tag in turn from the heap start, then writes the tag;
// free checks and writes back the block, then walks from the heap start to merge the predecessor
// one word at a time: not ready until the result word is taken
// reset: async active low, then a clearing pass over all 512 tags before the first word
`timescale 1ns / 1ps
module first_fit_heap_allocator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // request_bytes, address, zero pad
  input  logic         s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, payload_offset, used_bytes, free_bytes, peak_bytes, alloc_total,
  // free_total, block_count
  output logic [127:0] m_axis_tdata
);

  localparam int SW = ffha_pkg::SizeW;
  localparam int NW = ffha_pkg::NeedW;
  localparam int AW = ffha_pkg::AlignW;
  localparam int IW = ffha_pkg::IdxW;

  localparam logic [SW:0]   HeapC   = (SW+1)'(ffha_pkg::HeapBytes);
  localparam logic [SW-1:0] HdrC    = SW'(ffha_pkg::HeaderBytes);
  localparam logic [SW-1:0] SplitC  = SW'(ffha_pkg::HeaderBytes + ffha_pkg::MinPayload);
  localparam logic [NW-1:0] AlnMC   = NW'(ffha_pkg::AlignBytes - 1);

  ffha_pkg::state_e  state_q, state_d;
  ffha_pkg::mem_req_t req;
  ffha_pkg::tag_t    rd;
  ffha_pkg::status_e status_q, status_d;

  logic [IW-1:0] clr_q, clr_d;
  logic [SW:0]   pos_q, pos_d;
  logic [NW-1:0] need_q, need_d;
  logic [SW-1:0] blk_q, blk_d;
  logic [SW-1:0] msize_q, msize_d;
  logic [11:0]   off_q, off_d;
  logic [SW-1:0] used_q, used_d, freeb_q, freeb_d, peak_q, peak_d;
  logic [31:0]   acnt_q, acnt_d, fcnt_q, fcnt_d;
  logic [9:0]    bcnt_q, bcnt_d;

  logic [SW:0]   sum;
  logic [NW:0]   split_end;
  logic [SW-1:0] rem;
  logic [SW-1:0] fblk;
  logic [SW-1:0] nxt_ev;
  logic [SW-1:0] nxt_nx;

  ffha_tag_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rd)
  );

  always_comb begin
    sum       = {1'b0, pos_q[SW-1:0]} + {1'b0, rd.size};
    split_end = {{(NW-SW){1'b0}}, pos_q} + {1'b0, need_q};
    rem       = rd.size - need_q[SW-1:0];
    fblk      = SW'(s_axis_tdata[27:16]) - HdrC;
    nxt_ev    = blk_q + rd.size;
    nxt_nx    = blk_q + msize_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffha_pkg::S_CLEAR: if (clr_q == IW'(ffha_pkg::Depth - 1)) state_d = ffha_pkg::S_IDLE;
      ffha_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          if (!s_axis_tuser) begin
            state_d = (s_axis_tdata[15:0] == 16'd0) ? ffha_pkg::S_DONE : ffha_pkg::S_A_RD;
          end else if (s_axis_tdata[27:16] < 12'(ffha_pkg::HeaderBytes) ||
                       s_axis_tdata[16+AW-1:16] != '0) begin
            state_d = ffha_pkg::S_DONE;
          end else begin
            state_d = ffha_pkg::S_F_EV;
          end
        end
      end
      ffha_pkg::S_A_RD: state_d = (pos_q >= HeapC) ? ffha_pkg::S_DONE : ffha_pkg::S_A_EV;
      ffha_pkg::S_A_EV: begin
        if (rd.size == '0) state_d = ffha_pkg::S_DONE;
        else if (!rd.used && {{(NW-SW){1'b0}}, rd.size} >= need_q) state_d = ffha_pkg::S_A_WR;
        else state_d = ffha_pkg::S_A_RD;
      end
      ffha_pkg::S_A_WR: state_d = ffha_pkg::S_DONE;
      ffha_pkg::S_F_EV: begin
        if (rd.size == '0 || !rd.used) state_d = ffha_pkg::S_DONE;
        else if ({1'b0, blk_q} + {1'b0, rd.size} < HeapC) state_d = ffha_pkg::S_F_NX;
        else state_d = ffha_pkg::S_F_WB;
      end
      ffha_pkg::S_F_NX: state_d = ffha_pkg::S_F_WB;
      ffha_pkg::S_F_WB: state_d = ffha_pkg::S_F_PR;
      ffha_pkg::S_F_PR: state_d = (pos_q < {1'b0, blk_q}) ? ffha_pkg::S_F_PE : ffha_pkg::S_DONE;
      ffha_pkg::S_F_PE: begin
        if (rd.size == '0) state_d = ffha_pkg::S_DONE;
        else if (sum == {1'b0, blk_q}) state_d = rd.used ? ffha_pkg::S_DONE : ffha_pkg::S_F_PM;
        else state_d = ffha_pkg::S_F_PR;
      end
      ffha_pkg::S_F_PM: state_d = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE: if (m_axis_tready) state_d = ffha_pkg::S_IDLE;
      default: state_d = ffha_pkg::S_IDLE;
    endcase
  end

  // datapath and memory commands
  always_comb begin
    clr_d    = clr_q;
    pos_d    = pos_q;
    need_d   = need_q;
    blk_d    = blk_q;
    msize_d  = msize_q;
    off_d    = off_q;
    status_d = status_q;
    used_d   = used_q;
    freeb_d  = freeb_q;
    peak_d   = peak_q;
    acnt_d   = acnt_q;
    fcnt_d   = fcnt_q;
    bcnt_d   = bcnt_q;
    req      = '0;
    req.raddr = pos_q[AW+IW-1:AW];

    unique case (state_q)
      ffha_pkg::S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_q;
        req.wdata = (clr_q == '0) ? ffha_pkg::tag_t'{1'b0, HeapC[SW-1:0]} : '0;
        clr_d     = clr_q + IW'(1);
      end
      ffha_pkg::S_IDLE: begin
        off_d  = '0;
        pos_d  = '0;
        need_d = ((NW'(s_axis_tdata[15:0]) + AlnMC) & ~AlnMC) + NW'(HdrC);
        blk_d  = fblk;
        req.raddr = fblk[AW+IW-1:AW];
        if (!s_axis_tuser) begin
          status_d = (s_axis_tdata[15:0] == 16'd0) ? ffha_pkg::ST_ZERO : ffha_pkg::ST_OK;
        end else if (s_axis_tdata[27:16] == 12'd0) begin
          status_d = ffha_pkg::ST_NULL;
        end else if (s_axis_tdata[27:16] < 12'(ffha_pkg::HeaderBytes) ||
                     s_axis_tdata[16+AW-1:16] != '0) begin
          status_d = ffha_pkg::ST_NOTBLK;
        end else begin
          status_d = ffha_pkg::ST_OK;
        end
      end
      ffha_pkg::S_A_RD: begin
        if (pos_q >= HeapC) status_d = ffha_pkg::ST_NOFIT;
      end
      ffha_pkg::S_A_EV: begin
        if (rd.size == '0) begin
          status_d = ffha_pkg::ST_NOFIT;
        end else if (!rd.used && {{(NW-SW){1'b0}}, rd.size} >= need_q) begin
          if (rem >= SplitC && split_end < (NW+1)'(ffha_pkg::HeapBytes)) begin
            req.we    = 1'b1;
            req.waddr = split_end[AW+IW-1:AW];
            req.wdata = ffha_pkg::tag_t'{1'b0, rem};
            msize_d   = need_q[SW-1:0];
            bcnt_d    = bcnt_q + 10'd1;
          end else begin
            msize_d = rd.size;
          end
        end else begin
          pos_d = sum;
        end
      end
      ffha_pkg::S_A_WR: begin
        req.we    = 1'b1;
        req.waddr = pos_q[AW+IW-1:AW];
        req.wdata = ffha_pkg::tag_t'{1'b1, msize_q};
        used_d    = used_q + msize_q;
        freeb_d   = freeb_q - msize_q;
        acnt_d    = acnt_q + 32'd1;
        if (used_q + msize_q > peak_q) peak_d = used_q + msize_q;
        off_d     = pos_q[11:0] + 12'(ffha_pkg::HeaderBytes);
      end
      ffha_pkg::S_F_EV: begin
        req.raddr = nxt_ev[AW+IW-1:AW];
        msize_d   = rd.size;
        if (rd.size == '0) begin
          status_d = ffha_pkg::ST_NOTBLK;
        end else if (!rd.used) begin
          status_d = ffha_pkg::ST_TWICE;
        end else begin
          used_d  = used_q - rd.size;
          freeb_d = freeb_q + rd.size;
          fcnt_d  = fcnt_q + 32'd1;
        end
      end
      ffha_pkg::S_F_NX: begin
        if (rd.size != '0 && !rd.used) begin
          req.we    = 1'b1;
          req.waddr = nxt_nx[AW+IW-1:AW];
          req.wdata = '0;
          msize_d   = msize_q + rd.size;
          bcnt_d    = bcnt_q - 10'd1;
        end
      end
      ffha_pkg::S_F_WB: begin
        req.we    = 1'b1;
        req.waddr = blk_q[AW+IW-1:AW];
        req.wdata = ffha_pkg::tag_t'{1'b0, msize_q};
        pos_d     = '0;
      end
      ffha_pkg::S_F_PR: ;
      ffha_pkg::S_F_PE: begin
        if (rd.size != '0 && sum == {1'b0, blk_q}) begin
          if (!rd.used) begin
            req.we    = 1'b1;
            req.waddr = pos_q[AW+IW-1:AW];
            req.wdata = ffha_pkg::tag_t'{1'b0, rd.size + msize_q};
          end
        end else begin
          pos_d = sum;
        end
      end
      ffha_pkg::S_F_PM: begin
        req.we    = 1'b1;
        req.waddr = blk_q[AW+IW-1:AW];
        req.wdata = '0;
        bcnt_d    = bcnt_q - 10'd1;
      end
      ffha_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ffha_pkg::S_CLEAR;
      clr_q    <= '0;
      status_q <= ffha_pkg::ST_OK;
      used_q   <= HdrC;
      freeb_q  <= SW'(ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes);
      peak_q   <= HdrC;
      acnt_q   <= '0;
      fcnt_q   <= '0;
      bcnt_q   <= 10'd1;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      status_q <= status_d;
      used_q   <= used_d;
      freeb_q  <= freeb_d;
      peak_q   <= peak_d;
      acnt_q   <= acnt_d;
      fcnt_q   <= fcnt_d;
      bcnt_q   <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    need_q  <= need_d;
    blk_q   <= blk_d;
    msize_q <= msize_d;
    off_q   <= off_d;
  end

  assign s_axis_tready = (state_q == ffha_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == ffha_pkg::S_DONE);
  assign m_axis_tdata  = {bcnt_q, fcnt_q, acnt_q, peak_q, freeb_q, used_q, off_q, status_q};

endmodule

@@ rtl/ffha_tag_ram.sv @@
// block tag memory, one write and one registered read port
`timescale 1ns / 1ps
module ffha_tag_ram (
  input  logic              clk_i,
  input  ffha_pkg::mem_req_t req_i,
  output ffha_pkg::tag_t    rdata_o
);

  ffha_pkg::tag_t mem_q [ffha_pkg::Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

@@ rtl/ffha_checker.sv @@
// port-level assertions for the allocator, bound to the top level
`timescale 1ns / 1ps
module ffha_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready while a result word is pending");

  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 13'(m_axis_tdata[27:15] + m_axis_tdata[40:28]) == 13'd4096)
    else $error("used and free bytes out of balance");

  a_fail_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] != 3'd0) |-> m_axis_tdata[14:3] == 12'd0)
    else $error("offset on a failed request");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word dropped or changed while stalled");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

@@ bench/first_fit_heap_allocator_top_test.sv @@
// self-checking testbench for the first-fit heap allocator: directed table, then random traffic
`timescale 1ns / 1ps
module first_fit_heap_allocator_top_test;

  typedef enum logic {CMD_ALLOC = 1'b0, CMD_FREE = 1'b1} cmd_e;

  typedef struct {
    ffha_pkg::status_e status;
    logic [11:0] offset;
    logic [12:0] used_bytes;
    logic [12:0] free_bytes;
    logic [12:0] peak_bytes;
    logic [31:0] alloc_total;
    logic [31:0] free_total;
    logic [9:0]  block_count;
  } heap_result_t;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] req;
    logic [11:0] addr;
    bit          typed;
    ffha_pkg::status_e status;
    logic [11:0] offset;
  } heap_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  first_fit_heap_allocator_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // heap image kept by the predictor
  int          blk_size [ffha_pkg::HeapBytes];
  bit          blk_used [ffha_pkg::HeapBytes];
  bit          blk_start[ffha_pkg::HeapBytes];
  logic [12:0] used_b, free_b, peak_b;
  logic [31:0] n_alloc, n_free;
  logic [9:0]  n_blocks;

  heap_result_t expected_q[$];
  int           live_q[$];
  int           freed_q[$];
  int           send_idle, recv_stall;
  int           hold_req, hold_seen, hold_left;
  int           fails;

  function automatic ffha_pkg::status_e heap_alloc(int req, output int off);
    int need, pos, sz, rem;
    off = 0;
    if (req == 0) return ffha_pkg::ST_ZERO;
    need = ((req + ffha_pkg::AlignBytes - 1) / ffha_pkg::AlignBytes) * ffha_pkg::AlignBytes
           + ffha_pkg::HeaderBytes;
    pos = 0;
    while (pos < ffha_pkg::HeapBytes) begin
      sz = blk_size[pos];
      if (sz == 0) break;
      if (!blk_used[pos] && sz >= need) break;
      pos += sz;
    end
    if (pos >= ffha_pkg::HeapBytes || blk_size[pos] == 0) return ffha_pkg::ST_NOFIT;
    sz = blk_size[pos];
    rem = sz - need;
    if (rem >= ffha_pkg::HeaderBytes + ffha_pkg::MinPayload &&
        pos + need < ffha_pkg::HeapBytes) begin
      blk_size[pos + need] = rem;
      blk_used[pos + need] = 0;
      blk_start[pos + need] = 1;
      sz = need;
      n_blocks++;
    end
    blk_size[pos] = sz;
    blk_used[pos] = 1;
    used_b += 13'(sz);
    free_b -= 13'(sz);
    n_alloc++;
    if (used_b > peak_b) peak_b = used_b;
    off = pos + ffha_pkg::HeaderBytes;
    return ffha_pkg::ST_OK;
  endfunction

  function automatic ffha_pkg::status_e heap_free(int addr);
    int blk, sz, nxt, prv, p, ps;
    if (addr == 0) return ffha_pkg::ST_NULL;
    if (addr < ffha_pkg::HeaderBytes) return ffha_pkg::ST_NOTBLK;
    blk = addr - ffha_pkg::HeaderBytes;
    if (blk >= ffha_pkg::HeapBytes || !blk_start[blk]) return ffha_pkg::ST_NOTBLK;
    if (!blk_used[blk]) return ffha_pkg::ST_TWICE;
    sz = blk_size[blk];
    used_b -= 13'(sz);
    free_b += 13'(sz);
    n_free++;
    nxt = blk + sz;
    if (nxt < ffha_pkg::HeapBytes && blk_start[nxt] && !blk_used[nxt]) begin
      sz += blk_size[nxt];
      blk_start[nxt] = 0;
      blk_size[nxt] = 0;
      blk_used[nxt] = 0;
      n_blocks--;
    end
    blk_size[blk] = sz;
    blk_used[blk] = 0;
    prv = ffha_pkg::HeapBytes;
    p = 0;
    while (p < blk) begin
      ps = blk_size[p];
      if (ps == 0) break;
      if (p + ps == blk) begin
        prv = p;
        break;
      end
      p += ps;
    end
    if (prv < ffha_pkg::HeapBytes && !blk_used[prv]) begin
      blk_size[prv] = blk_size[prv] + sz;
      blk_start[blk] = 0;
      blk_size[blk] = 0;
      n_blocks--;
    end
    return ffha_pkg::ST_OK;
  endfunction

  function automatic heap_result_t heap_predict(cmd_e cmd, int req, int addr);
    heap_result_t r;
    int off;
    off = 0;
    if (cmd == CMD_ALLOC) begin
      r.status = heap_alloc(req, off);
      if (r.status == ffha_pkg::ST_OK) live_q.push_back(off);
    end else begin
      r.status = heap_free(addr);
      if (r.status == ffha_pkg::ST_OK) begin
        foreach (live_q[i]) if (live_q[i] == addr) begin
          live_q.delete(i);
          break;
        end
        freed_q.push_back(addr);
        if (freed_q.size() > 16) void'(freed_q.pop_front());
      end
    end
    r.offset = 12'(off);
    r.used_bytes = used_b;
    r.free_bytes = free_b;
    r.peak_bytes = peak_b;
    r.alloc_total = n_alloc;
    r.free_total = n_free;
    r.block_count = n_blocks;
    return r;
  endfunction

  task automatic send_word(cmd_e cmd, logic [15:0] req, logic [11:0] addr,
                           bit typed = 0, ffha_pkg::status_e st = ffha_pkg::ST_OK,
                           logic [11:0] off = '0);
    heap_result_t r;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, addr, req};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    r = heap_predict(cmd, int'(req), int'(addr));
    if (typed) begin
      r.status = st;
      r.offset = off;
    end
    expected_q.push_back(r);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random;
    int r, pick;
    logic [15:0] req;
    r = $urandom_range(99);
    if (r < 48) begin
      pick = $urandom_range(99);
      if (pick < 2) req = 16'd0;
      else if (pick < 5) req = 16'($urandom());
      else if (pick < 15) req = 16'($urandom_range(1, 1024));
      else req = 16'($urandom_range(1, 160));
      send_word(CMD_ALLOC, req, 12'($urandom()));
    end else if (r < 90 && live_q.size() != 0) begin
      send_word(CMD_FREE, 16'($urandom()),
                12'(live_q[$urandom_range(live_q.size() - 1)]));
    end else if (r < 95 && freed_q.size() != 0) begin
      send_word(CMD_FREE, 16'($urandom()),
                12'(freed_q[$urandom_range(freed_q.size() - 1)]));
    end else begin
      send_word(CMD_FREE, 16'($urandom()), (r & 1) ? 12'd0 : 12'($urandom()));
    end
  endtask

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk_i) begin
    heap_result_t e;
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word");
        fails++;
      end else begin
        e = expected_q.pop_front();
        check_field("status", e.status, m_axis_tdata[2:0]);
        check_field("payload_offset", e.offset, m_axis_tdata[14:3]);
        check_field("used_bytes", e.used_bytes, m_axis_tdata[27:15]);
        check_field("free_bytes", e.free_bytes, m_axis_tdata[40:28]);
        check_field("peak_bytes", e.peak_bytes, m_axis_tdata[53:41]);
        check_field("alloc_total", e.alloc_total, m_axis_tdata[85:54]);
        check_field("free_total", e.free_total, m_axis_tdata[117:86]);
        check_field("block_count", e.block_count, m_axis_tdata[127:118]);
      end
    end
  end

  initial begin
    #100ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    heap_row_t rows[$];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    fails = 0;
    foreach (blk_size[i]) begin
      blk_size[i] = 0;
      blk_used[i] = 0;
      blk_start[i] = 0;
    end
    blk_size[0] = ffha_pkg::HeapBytes;
    blk_start[0] = 1;
    used_b = 13'(ffha_pkg::HeaderBytes);
    free_b = 13'(ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes);
    peak_b = 13'(ffha_pkg::HeaderBytes);
    n_alloc = 0;
    n_free = 0;
    n_blocks = 1;

    rows = '{
      '{CMD_ALLOC, 16'd0,     12'hfff, 1, ffha_pkg::ST_ZERO,   12'd0},
      '{CMD_ALLOC, 16'hffff,  12'd0,   1, ffha_pkg::ST_NOFIT,  12'd0},
      '{CMD_FREE,  16'hffff,  12'd0,   1, ffha_pkg::ST_NULL,   12'd0},
      '{CMD_FREE,  16'd0,     12'd8,   1, ffha_pkg::ST_NOTBLK, 12'd0},
      '{CMD_FREE,  16'd0,     12'hfff, 1, ffha_pkg::ST_NOTBLK, 12'd0},
      '{CMD_ALLOC, 16'd1,     12'd0,   1, ffha_pkg::ST_OK,     12'd16},
      '{CMD_FREE,  16'd0,     12'd16,  1, ffha_pkg::ST_OK,     12'd0},
      '{CMD_FREE,  16'd0,     12'd16,  1, ffha_pkg::ST_TWICE,  12'd0},
      '{CMD_ALLOC, 16'd4081,  12'd0,   1, ffha_pkg::ST_NOFIT,  12'd0},
      '{CMD_ALLOC, 16'd4080,  12'd0,   1, ffha_pkg::ST_OK,     12'd16},
      '{CMD_ALLOC, 16'd1,     12'd0,   1, ffha_pkg::ST_NOFIT,  12'd0},
      '{CMD_FREE,  16'd0,     12'd16,  1, ffha_pkg::ST_OK,     12'd0},
      '{CMD_ALLOC, 16'd100,   12'd0,   0, ffha_pkg::ST_OK,     12'd0},
      '{CMD_ALLOC, 16'd8,     12'd0,   0, ffha_pkg::ST_OK,     12'd0},
      '{CMD_ALLOC, 16'd33,    12'd0,   0, ffha_pkg::ST_OK,     12'd0},
      '{CMD_FREE,  16'd0,     12'd17,  1, ffha_pkg::ST_NOTBLK, 12'd0},
      '{CMD_FREE,  16'd0,     12'd128, 0, ffha_pkg::ST_OK,     12'd0},
      '{CMD_FREE,  16'd0,     12'd16,  0, ffha_pkg::ST_OK,     12'd0},
      '{CMD_FREE,  16'd0,     12'd152, 0, ffha_pkg::ST_OK,     12'd0},
      '{CMD_ALLOC, 16'd4000,  12'd0,   0, ffha_pkg::ST_OK,     12'd0},
      '{CMD_ALLOC, 16'd40,    12'd0,   0, ffha_pkg::ST_OK,     12'd0},
      '{CMD_FREE,  16'd0,     12'd16,  0, ffha_pkg::ST_OK,     12'd0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i])
      send_word(rows[i].cmd, rows[i].req, rows[i].addr, rows[i].typed,
                rows[i].status, rows[i].offset);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 45 : 25) : 0;
      recv_stall = (ph == 2) ? 45 : ((ph == 3) ? 25 : 0);
      for (int n = 0; n < 257; n++) begin
        if (ph == 0 && n == 100) hold_req <= hold_req + 1;
        send_random();
      end
      drain();
    end

    repeat (1200) @(posedge clk_i);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
